>>> rtl/core/wrs_pkg.sv
package wrs_pkg;

   // default sizing handed to the top level parameters
   localparam int MAX_ENTRIES_DEF = 16;
   localparam int WEIGHT_BITS_DEF = 16;

   // fixed port field widths
   localparam int CMD_W    = 2;
   localparam int WIN_W    = 16;
   localparam int IDX_W    = 4;
   localparam int RAND_W   = 16;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 20;
   localparam int COUNT_W  = 5;

   // command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REPLACE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic                latch;      // capture the request beat
      logic                clear;      // empty the table
      logic                append;     // store weight at the end
      logic                rd_index;   // read old weight at entry index
      logic                replace;    // write new weight, adjust total
      logic                sel_start;  // scale draw, read first entry
      logic                walk_step;  // accumulate, read next entry
      logic                finish;     // launch the result beat
      logic                hit;        // result carries a chosen entry
      logic [STATUS_W-1:0] status;
   } wrs_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             full;
      logic             idx_ok;
      logic             sel_ok;
      logic             walk_done;
   } wrs_stat_type;

endpackage

>>> rtl/core/wrs_ram.sv
module wrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic                                            rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/wrs_ctrl.sv
module wrs_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  wrs_pkg::wrs_stat_type stat,
   output wrs_pkg::wrs_cmd_type  cmd
);
   import wrs_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_REPL = 2'd2;
   localparam logic [1:0] ST_WALK = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and command decode
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (stat.cmd)
               CMD_CLEAR: begin
                  cmd.clear  = 1'b1;
                  cmd.finish = 1'b1;
                  cmd.status = STAT_OK;
                  state_in   = ST_IDLE;
               end
               CMD_APPEND: begin
                  cmd.finish = 1'b1;
                  state_in   = ST_IDLE;
                  if (stat.full) begin
                     cmd.status = STAT_FULL;
                  end else begin
                     cmd.append = 1'b1;
                     cmd.status = STAT_OK;
                  end
               end
               CMD_REPLACE: begin
                  if (stat.idx_ok) begin
                     cmd.rd_index = 1'b1;
                     state_in     = ST_REPL;
                  end else begin
                     cmd.finish = 1'b1;
                     cmd.status = STAT_BAD_INDEX;
                     state_in   = ST_IDLE;
                  end
               end
               default: begin
                  if (stat.sel_ok) begin
                     cmd.sel_start = 1'b1;
                     state_in      = ST_WALK;
                  end else begin
                     cmd.finish = 1'b1;
                     cmd.status = STAT_OK;
                     state_in   = ST_IDLE;
                  end
               end
            endcase
         end
         ST_REPL: begin
            cmd.replace = 1'b1;
            cmd.finish  = 1'b1;
            cmd.status  = STAT_OK;
            state_in    = ST_IDLE;
         end
         ST_WALK: begin
            if (stat.walk_done) begin
               cmd.finish = 1'b1;
               cmd.hit    = 1'b1;
               cmd.status = STAT_OK;
               state_in   = ST_IDLE;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

>>> rtl/core/wrs_dp.sv
module wrs_dp #(
   parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  wrs_pkg::wrs_cmd_type            cmd,
   output wrs_pkg::wrs_stat_type           stat,
   input  logic [wrs_pkg::CMD_W-1:0]       req_command,
   input  logic [wrs_pkg::WIN_W-1:0]       req_weight,
   input  logic [wrs_pkg::IDX_W-1:0]       req_entry_index,
   input  logic [wrs_pkg::RAND_W-1:0]      req_random_fraction,
   output logic                            rsp_valid,
   output logic [wrs_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_found,
   output logic [wrs_pkg::IDX_W-1:0]       rsp_chosen_index,
   output logic [wrs_pkg::TOTAL_W-1:0]     rsp_total_weight,
   output logic [wrs_pkg::COUNT_W-1:0]     rsp_entry_count
);
   import wrs_pkg::*;

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int SW = WEIGHT_BITS + CW;
   localparam int PW = RAND_W + SW;

   // captured request
   logic [CMD_W-1:0]       cmd_ff;
   logic [WEIGHT_BITS-1:0] w_ff;
   logic [IDX_W-1:0]       idx_ff;
   logic [RAND_W-1:0]      r_ff;

   // table bookkeeping and walk state
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [SW-1:0]          sum_ff;
   logic [SW-1:0]          sum_in;
   logic [SW-1:0]          alpha_ff;
   logic [SW-1:0]          prefix_ff;
   logic [CW-1:0]          ck_ff;

   // result beat
   logic                   valid_ff;
   logic [STATUS_W-1:0]    status_ff;
   logic                   found_ff;
   logic [CW-1:0]          chosen_ff;

   logic [WEIGHT_BITS+WIN_W-1:0] w_ext;
   logic [AW+IDX_W-1:0]          idx_ext;
   logic [AW-1:0]                idx_addr;
   logic [CW-1:0]                ck_next;
   logic [PW-1:0]                product;
   logic [SW-1:0]                rd_weight;
   logic [SW-1:0]                prefix_next;
   logic [WEIGHT_BITS-1:0]       ram_rdata;
   logic                         ram_we;
   logic [AW-1:0]                ram_waddr;
   logic                         ram_re;
   logic [AW-1:0]                ram_raddr;
   logic [SW+TOTAL_W-1:0]        sum_ext;
   logic [CW+COUNT_W-1:0]        count_ext;
   logic [CW+IDX_W-1:0]          chosen_ext;

   assign w_ext    = (WEIGHT_BITS + WIN_W)'(req_weight);
   assign idx_ext  = (AW + IDX_W)'(idx_ff);
   assign idx_addr = idx_ext[AW-1:0];
   assign ck_next  = ck_ff + CW'(1);

   // status toward the controller
   assign stat.cmd       = cmd_ff;
   assign stat.full      = (count_ff == CW'(MAX_ENTRIES));
   assign stat.idx_ok    = (32'(idx_ff) < 32'(count_ff));
   assign stat.sel_ok    = (count_ff != '0) && (sum_ff != '0);
   assign stat.walk_done = (prefix_next > alpha_ff) || (ck_next == count_ff);

   // weight table ports
   always_comb begin
      ram_we    = cmd.append || cmd.replace;
      ram_waddr = cmd.append ? count_ff[AW-1:0] : idx_addr;
      ram_re    = cmd.sel_start || cmd.rd_index || cmd.walk_step;
      if (cmd.rd_index) begin
         ram_raddr = idx_addr;
      end else if (cmd.walk_step) begin
         ram_raddr = ck_next[AW-1:0];
      end else begin
         ram_raddr = '0;
      end
   end

   wrs_ram #(
      .WIDTH(WEIGHT_BITS),
      .DEPTH(MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (w_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rd_weight   = SW'(ram_rdata);
   assign prefix_next = prefix_ff + rd_weight;

   // draw scaled by the total
   assign product = PW'(r_ff) * PW'(sum_ff);

   // count and total update
   always_comb begin
      count_in = count_ff;
      sum_in   = sum_ff;
      if (cmd.clear) begin
         count_in = '0;
         sum_in   = '0;
      end else if (cmd.append) begin
         count_in = count_ff + CW'(1);
         sum_in   = sum_ff + SW'(w_ff);
      end else if (cmd.replace) begin
         sum_in   = sum_ff - rd_weight + SW'(w_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
         valid_ff <= cmd.finish;
      end
   end

   // request capture, walk registers and result payload
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff <= req_command;
         w_ff   <= w_ext[WEIGHT_BITS-1:0];
         idx_ff <= req_entry_index;
         r_ff   <= req_random_fraction;
      end
      if (cmd.sel_start) begin
         alpha_ff  <= product[PW-1:RAND_W];
         prefix_ff <= '0;
         ck_ff     <= '0;
      end else if (cmd.walk_step) begin
         prefix_ff <= prefix_next;
         ck_ff     <= ck_next;
      end
      if (cmd.finish) begin
         status_ff <= cmd.status;
         found_ff  <= cmd.hit;
         chosen_ff <= cmd.hit ? ck_ff : '0;
      end
   end

   // result ports
   assign sum_ext    = (SW + TOTAL_W)'(sum_ff);
   assign count_ext  = (CW + COUNT_W)'(count_ff);
   assign chosen_ext = (CW + IDX_W)'(chosen_ff);

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found        = found_ff;
   assign rsp_chosen_index = chosen_ext[IDX_W-1:0];
   assign rsp_total_weight = sum_ext[TOTAL_W-1:0];
   assign rsp_entry_count  = count_ext[COUNT_W-1:0];

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_ENTRIES)
      else $error("entry count above table depth");

   a_hit_in_table: assert property (@(posedge clock) disable iff (reset)
      valid_ff && found_ff |-> (status_ff == STAT_OK) && (chosen_ff < count_ff))
      else $error("chosen entry outside stored entries");

   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      valid_ff |=> !valid_ff)
      else $error("result beat held longer than one cycle");

   a_walk_total: assert property (@(posedge clock) disable iff (reset)
      cmd.walk_step |-> (prefix_next <= sum_ff))
      else $error("prefix sum exceeded total during walk");

endmodule

>>> rtl/core/weighted_random_selector_unit.sv
// channel   ports                                     handshake
// request   req_command req_weight req_entry_index    start high, busy low
//           req_random_fraction
// result    rsp_status rsp_found rsp_chosen_index     rsp_valid, one cycle
//           rsp_total_weight rsp_entry_count
//
// clear and append: request latched, then executed and the result strobe set
// replace: old weight read from the table ram, then the new one written back
// select: walk goes over the entries up to the chosen one (at most
//   the stored count); one table ram read and one add/compare per entry
// reset: synchronous, empties the table; the weight ram itself is not cleared
// results cannot be stalled; a new beat is taken in the cycle a result shows
module weighted_random_selector_unit #(
   parameter int MAX_ENTRIES = wrs_pkg::MAX_ENTRIES_DEF,
   parameter int WEIGHT_BITS = wrs_pkg::WEIGHT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [wrs_pkg::CMD_W-1:0]       req_command,
   input  logic [wrs_pkg::WIN_W-1:0]       req_weight,
   input  logic [wrs_pkg::IDX_W-1:0]       req_entry_index,
   input  logic [wrs_pkg::RAND_W-1:0]      req_random_fraction,
   output logic                            rsp_valid,
   output logic [wrs_pkg::STATUS_W-1:0]    rsp_status,
   output logic                            rsp_found,
   output logic [wrs_pkg::IDX_W-1:0]       rsp_chosen_index,
   output logic [wrs_pkg::TOTAL_W-1:0]     rsp_total_weight,
   output logic [wrs_pkg::COUNT_W-1:0]     rsp_entry_count
);
   import wrs_pkg::*;

   wrs_cmd_type  cmd;
   wrs_stat_type stat;

   // sequencer
   wrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // table, totals and select walk
   wrs_dp #(
      .MAX_ENTRIES(MAX_ENTRIES),
      .WEIGHT_BITS(WEIGHT_BITS)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_command         (req_command),
      .req_weight          (req_weight),
      .req_entry_index     (req_entry_index),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_found           (rsp_found),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_total_weight    (rsp_total_weight),
      .rsp_entry_count     (rsp_entry_count)
   );

endmodule

>>> tb/sv/weighted_random_selector_unit_tb.sv
`timescale 1ns / 100ps

module weighted_random_selector_unit_tb;
   import wrs_pkg::*;

   localparam int TABLE_DEPTH  = MAX_ENTRIES_DEF;
   localparam int ITEM_TARGET  = 1050;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                found;
      logic [IDX_W-1:0]    chosen;
      logic [TOTAL_W-1:0]  total;
      logic [COUNT_W-1:0]  count;
   } rsp_beat_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [CMD_W-1:0]    req_command;
   logic [WIN_W-1:0]    req_weight;
   logic [IDX_W-1:0]    req_entry_index;
   logic [RAND_W-1:0]   req_random_fraction;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic                rsp_found;
   logic [IDX_W-1:0]    rsp_chosen_index;
   logic [TOTAL_W-1:0]  rsp_total_weight;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // shadow copy of the selector state
   logic [WIN_W-1:0]    shadow_weights [TABLE_DEPTH];
   logic [COUNT_W-1:0]  shadow_count;
   logic [TOTAL_W-1:0]  shadow_sum;

   rsp_beat_type        pending_rsp [$];
   int                  beats_sent;
   int                  mismatches;
   int                  cycle_count;
   bit                  burst_mode;

   weighted_random_selector_unit i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_weight          (req_weight),
      .req_entry_index     (req_entry_index),
      .req_random_fraction (req_random_fraction),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_found           (rsp_found),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_total_weight    (rsp_total_weight),
      .rsp_entry_count     (rsp_entry_count)
   );

   // clock, 20 ns period
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("weighted_random_selector_unit: mismatch");
         $finish;
      end
   end

   // expected result of one command, updates the shadow state
   task automatic predict_selection(input logic [CMD_W-1:0] cmd, input logic [WIN_W-1:0] w,
                                    input logic [IDX_W-1:0] idx,
                                    input logic [RAND_W-1:0] r, output rsp_beat_type res);
      logic [35:0]        alpha;
      logic [TOTAL_W-1:0] prefix;
      bit                 hit;
      res = '0;
      res.status = STAT_OK;
      case (cmd)
         CMD_CLEAR: begin
            shadow_count = '0;
            shadow_sum   = '0;
         end
         CMD_APPEND: begin
            if (shadow_count >= TABLE_DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               shadow_weights[shadow_count] = w;
               shadow_count = shadow_count + 1'b1;
               shadow_sum   = shadow_sum + w;
            end
         end
         CMD_REPLACE: begin
            if (idx >= shadow_count) begin
               res.status = STAT_BAD_INDEX;
            end else begin
               shadow_sum = shadow_sum - shadow_weights[idx] + w;
               shadow_weights[idx] = w;
            end
         end
         default: begin
            // roulette walk over the prefix sums
            if (shadow_count != 0 && shadow_sum != 0) begin
               alpha  = (36'(r) * 36'(shadow_sum)) >> 16;
               prefix = '0;
               hit    = 1'b0;
               for (int i = 0; i < TABLE_DEPTH; i++) begin
                  if (!hit && i < shadow_count) begin
                     prefix = prefix + shadow_weights[i];
                     if (36'(prefix) > alpha) begin
                        res.chosen = IDX_W'(i);
                        hit        = 1'b1;
                     end
                  end
               end
               if (!hit) res.chosen = IDX_W'(shadow_count - 1'b1);
               res.found = 1'b1;
            end
         end
      endcase
      res.total = shadow_sum;
      res.count = shadow_count;
   endtask

   // send one request beat after a random gap, or with no gap in burst mode
   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [WIN_W-1:0] w,
                            input logic [IDX_W-1:0] idx, input logic [RAND_W-1:0] r);
      int           gap;
      rsp_beat_type res;
      gap = burst_mode ? 0 : $urandom_range(0, 18);
      @(negedge clock);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start               <= 1'b1;
      req_command         <= cmd;
      req_weight          <= w;
      req_entry_index     <= idx;
      req_random_fraction <= r;
      do @(posedge clock); while (busy);
      predict_selection(cmd, w, idx, r, res);
      pending_rsp.insert(pending_rsp.size(), res);
      beats_sent++;
   endtask

   // result checker
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_valid) begin
         got = '{rsp_status, rsp_found, rsp_chosen_index, rsp_total_weight, rsp_entry_count};
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"unexpected result beat: status %0d found %0d index %0d ",
                         "total %0d count %0d"},
                        got.status, got.found, got.chosen, got.total, got.count);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display({"result mismatch: expected status %0d found %0d index %0d ",
                            "total %0d count %0d, actual %0d %0d %0d %0d %0d"},
                           want.status, want.found, want.chosen, want.total, want.count,
                           got.status, got.found, got.chosen, got.total, got.count);
            end
         end
      end
   end

   // weight mix: zero, full scale, tiny and anything
   function automatic logic [WIN_W-1:0] pick_weight();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return WIN_W'($urandom_range(0, 15));
         default: return WIN_W'($urandom);
      endcase
   endfunction

   // select and replace on an empty table
   task automatic test_empty_table();
      send_beat(CMD_SELECT, '0, '0, '1);
      send_beat(CMD_REPLACE, '1, '0, '0);
   endtask

   // zero total at a mid draw, then full-scale weight at the top draw
   task automatic test_zero_total();
      send_beat(CMD_APPEND, '0, '0, '0);
      send_beat(CMD_SELECT, '0, '0, 16'h8000);
      send_beat(CMD_REPLACE, '1, '0, '0);
      send_beat(CMD_SELECT, '0, '0, '1);
   endtask

   // fill the table, overflow it, zero the last entry, select at the lowest draw, clear
   task automatic test_full_table();
      for (int i = 1; i < TABLE_DEPTH; i++)
         send_beat(CMD_APPEND, (i == TABLE_DEPTH - 1) ? '1 : pick_weight(), '0, '0);
      send_beat(CMD_APPEND, 16'h1234, '0, '0);
      send_beat(CMD_REPLACE, '0, IDX_W'(TABLE_DEPTH - 1), '0);
      send_beat(CMD_SELECT, '0, '0, '0);
      send_beat(CMD_CLEAR, '0, '0, '0);
   endtask

   // clear, fill, then a mix of selects, replaces and appends, with noise
   task automatic test_random_sequences(input int target);
      int n_fill;
      int n_ops;
      while (beats_sent < target) begin
         burst_mode = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 7) == 0) begin
            send_beat(CMD_W'($urandom), WIN_W'($urandom), IDX_W'($urandom), RAND_W'($urandom));
         end else begin
            send_beat(CMD_CLEAR, WIN_W'($urandom), IDX_W'($urandom), RAND_W'($urandom));
            n_fill = $urandom_range(1, TABLE_DEPTH + 1);
            for (int i = 0; i < n_fill; i++)
               send_beat(CMD_APPEND, pick_weight(), IDX_W'($urandom), RAND_W'($urandom));
            n_ops = $urandom_range(4, 20);
            for (int i = 0; i < n_ops; i++) begin
               case ($urandom_range(0, 9))
                  0, 1:    send_beat(CMD_REPLACE, pick_weight(), IDX_W'($urandom),
                                     RAND_W'($urandom));
                  2:       send_beat(CMD_APPEND, pick_weight(), IDX_W'($urandom),
                                     RAND_W'($urandom));
                  default: send_beat(CMD_SELECT, WIN_W'($urandom), IDX_W'($urandom),
                                     RAND_W'($urandom));
               endcase
            end
         end
      end
      burst_mode = 1'b0;
   endtask

   // sender holds off until every result is back
   task automatic test_drain_pause();
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   initial begin
      reset               = 1'b1;
      start               = 1'b0;
      req_command         = CMD_CLEAR;
      req_weight          = '0;
      req_entry_index     = '0;
      req_random_fraction = '0;
      shadow_count        = '0;
      shadow_sum          = '0;
      beats_sent          = 0;
      mismatches          = 0;
      cycle_count         = 0;
      burst_mode          = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_table();
      test_zero_total();
      test_full_table();
      test_random_sequences(ITEM_TARGET / 2);
      test_drain_pause();
      test_random_sequences(ITEM_TARGET);

      // drain and settle
      @(negedge clock);
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("weighted_random_selector_unit: match");
      end else begin
         $display("weighted_random_selector_unit: mismatch");
      end
      $finish;
   end

endmodule

>>> weighted_random_selector_unit.f
rtl/core/wrs_pkg.sv
rtl/core/wrs_ram.sv
rtl/core/wrs_ctrl.sv
rtl/core/wrs_dp.sv
rtl/core/weighted_random_selector_unit.sv
tb/sv/weighted_random_selector_unit_tb.sv
